// File: rtl/twsp_pkg.sv
package twsp_pkg;

	localparam int TEMP_W  = 11;
	localparam int STEP_W  = 12;
	localparam int PHASE_W = 2;
	localparam int COIL_W  = 4;
	localparam int ACT_W   = 3;
	localparam int CLASS_W = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// divider: dividend is span-bounded difference times travel
	localparam int DIVR_W    = TEMP_W;
	localparam int DIVD_W    = DIVR_W + STEP_W;
	localparam int DIV_CNT_W = $clog2(DIVD_W);

	localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_OPEN   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CLOSE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_HALF   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_AUTO   = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_BELOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_ABOVE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_OPEN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_OPEN   = 2'd3;

	localparam logic signed [TEMP_W-1:0] CLOSE_BELOW_RST = 11'sd230;
	localparam logic signed [TEMP_W-1:0] OPEN_ABOVE_RST  = 11'sd270;
	localparam logic [STEP_W-1:0]        FULL_OPEN_RST   = 12'd512;
	localparam logic [STEP_W-1:0]        HALF_OPEN_RST   = 12'd256;

	localparam logic [CLASS_W-1:0] CLASS_CLOSED  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_PARTIAL = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_HALF    = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_FULL    = 2'd3;

	localparam logic [COIL_W-1:0] COIL_OFF = 4'd0;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
		logic [COIL_W-1:0] pat;
		case (phase)
			2'd0:    pat = 4'd9;
			2'd1:    pat = 4'd3;
			2'd2:    pat = 4'd6;
			default: pat = 4'd12;
		endcase
		return pat;
	endfunction

endpackage

// File: rtl/twsp_if.sv
interface twsp_in_if import twsp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [TEMP_W-1:0] temp_tenths;

	modport source (output valid, output action, output temp_tenths, input ready);
	modport sink (input valid, input action, input temp_tenths, output ready);
endinterface

interface twsp_out_if import twsp_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COIL_W-1:0]     coil_pattern;
	logic [STEP_W-1:0]     position_steps;
	logic [STEP_W-1:0]     target_steps;
	logic                  manual_active;
	logic                  moving;
	logic [CLASS_W-1:0]    window_class;

	modport source (output valid, output coil_pattern, output position_steps,
		output target_steps, output manual_active, output moving, output window_class,
		input ready);
	modport sink (input valid, input coil_pattern, input position_steps,
		input target_steps, input manual_active, input moving, input window_class,
		output ready);
endinterface

// File: rtl/temperature_window_stepper_positioner.sv
// path from accept to result: tick and command items go through EXEC and FIN,
// an auto-mode sample inside the window through EXEC, MUL, LOAD, DIV (23-step divider) and FIN
// one item at a time: the next is accepted once the result is registered
// the restoring divider gives one quotient bit per cycle
// arst_n clears position, target, phase and mode; registers return to defaults
module temperature_window_stepper_positioner import twsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	twsp_in_if.sink               in_ch,
	twsp_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MUL, S_LOAD, S_DIV, S_FIN} state_t;

	state_t state_q;

	logic signed [TEMP_W-1:0] close_q;
	logic signed [TEMP_W-1:0] open_q;
	logic [STEP_W-1:0]        full_q;
	logic [STEP_W-1:0]        half_q;

	logic [STEP_W-1:0]  pos_q;
	logic [STEP_W-1:0]  tgt_q;
	logic [PHASE_W-1:0] phase_q;
	logic               manual_q;

	logic [ACT_W-1:0]         act_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [COIL_W-1:0]        coils_q;
	logic                     moving_q;
	logic [DIVR_W-1:0]        diff_q;
	logic [DIVR_W-1:0]        span_q;
	logic [DIVD_W-1:0]        prod_q;

	logic                  out_valid_q;
	logic [COIL_W-1:0]     out_coil_q;
	logic [STEP_W-1:0]     out_pos_q;
	logic [STEP_W-1:0]     out_tgt_q;
	logic                  out_manual_q;
	logic                  out_moving_q;
	logic [CLASS_W-1:0]    out_class_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic signed [TEMP_W:0] span_x;
	logic signed [TEMP_W:0] diff_x;
	logic [STEP_W-1:0]      half_cl;
	logic [STEP_W-1:0]      full_cl;
	logic [STEP_W-1:0]      gap;
	logic [STEP_W+8:0]      gap_sc;
	logic [STEP_W+8:0]      full_sc;
	logic [CLASS_W-1:0]     cls;
	logic [STEP_W-1:0]      quo_cl;
	logic                   out_free;

	logic                   step_up;
	logic                   step_dn;
	logic                   exec_step;
	logic [PHASE_W-1:0]     phase_nx;
	logic [COIL_W-1:0]      exec_coils;
	logic                   exec_map;

	twsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign span_x = {open_q[TEMP_W-1], open_q} - {close_q[TEMP_W-1], close_q};
	assign diff_x = {temp_q[TEMP_W-1], temp_q} - {close_q[TEMP_W-1], close_q};
	assign full_cl = full_q;
	assign half_cl = (half_q > full_q) ? full_q : half_q;
	assign quo_cl  = (div_rsp.quotient > DIVD_W'(full_q)) ? full_q
		: div_rsp.quotient[STEP_W-1:0];

	// tick stepping and the sample that needs the divider
	assign step_up    = (act_q == ACT_TICK) && (pos_q < tgt_q);
	assign step_dn    = (act_q == ACT_TICK) && (pos_q > tgt_q);
	assign exec_step  = step_up || step_dn;
	assign phase_nx   = step_up ? phase_q + 1'b1 : phase_q - 1'b1;
	assign exec_coils = exec_step ? coil_of(phase_nx) : COIL_OFF;
	assign exec_map   = (act_q == ACT_SAMPLE) && !manual_q && (temp_q >= close_q)
		&& (temp_q <= open_q) && (span_x > 0);

	// class of the current target
	assign gap     = (tgt_q > half_cl) ? tgt_q - half_cl : half_cl - tgt_q;
	assign gap_sc  = {gap, 9'b0};
	assign full_sc = ({9'b0, full_q} << 3) + ({9'b0, full_q} << 1);
	always_comb begin
		if (tgt_q == '0)
			cls = CLASS_CLOSED;
		else if (tgt_q >= full_q)
			cls = CLASS_FULL;
		else if (gap_sc <= full_sc)
			cls = CLASS_HALF;
		else
			cls = CLASS_PARTIAL;
	end

	assign div_req.start    = (state_q == S_LOAD);
	assign div_req.dividend = prod_q;
	assign div_req.divisor  = span_q;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q <= CLOSE_BELOW_RST;
			open_q  <= OPEN_ABOVE_RST;
			full_q  <= FULL_OPEN_RST;
			half_q  <= HALF_OPEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLOSE_BELOW: close_q <= cfg_data[TEMP_W-1:0];
				REG_OPEN_ABOVE:  open_q  <= cfg_data[TEMP_W-1:0];
				REG_FULL_OPEN:   full_q  <= cfg_data[STEP_W-1:0];
				REG_HALF_OPEN:   half_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			tgt_q       <= '0;
			phase_q     <= '0;
			manual_q    <= 1'b0;
			coils_q     <= COIL_OFF;
			moving_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					coils_q  <= exec_coils;
					moving_q <= exec_step;
					state_q  <= exec_map ? S_MUL : S_FIN;
					case (act_q)
						ACT_TICK: begin
							if (exec_step) begin
								pos_q   <= step_up ? pos_q + 1'b1 : pos_q - 1'b1;
								phase_q <= phase_nx;
							end
						end
						ACT_SAMPLE: begin
							if (!manual_q) begin
								if (temp_q < close_q)
									tgt_q <= '0;
								else if (temp_q > open_q)
									tgt_q <= full_cl;
								else if (span_x <= 0)
									tgt_q <= '0;
							end
						end
						ACT_OPEN: begin
							manual_q <= 1'b1;
							tgt_q    <= full_cl;
						end
						ACT_CLOSE: begin
							manual_q <= 1'b1;
							tgt_q    <= '0;
						end
						ACT_HALF: begin
							manual_q <= 1'b1;
							tgt_q    <= half_cl;
						end
						ACT_AUTO: manual_q <= 1'b0;
						default: ;
					endcase
				end
				S_MUL: state_q <= S_LOAD;
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						tgt_q   <= quo_cl;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			act_q  <= in_ch.action;
			temp_q <= in_ch.temp_tenths;
		end
		if (state_q == S_EXEC) begin
			diff_q <= diff_x[DIVR_W-1:0];
			span_q <= span_x[DIVR_W-1:0];
		end
		if (state_q == S_MUL)
			prod_q <= DIVD_W'(diff_q) * DIVD_W'(full_q);
		if (state_q == S_FIN && out_free) begin
			out_coil_q   <= coils_q;
			out_pos_q    <= pos_q;
			out_tgt_q    <= tgt_q;
			out_manual_q <= manual_q;
			out_moving_q <= moving_q;
			out_class_q  <= cls;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.coil_pattern   = out_coil_q;
	assign out_ch.position_steps = out_pos_q;
	assign out_ch.target_steps   = out_tgt_q;
	assign out_ch.manual_active  = out_manual_q;
	assign out_ch.moving         = out_moving_q;
	assign out_ch.window_class   = out_class_q;

`ifndef SYNTH
	a_step_drives_coils: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q == (coils_q != COIL_OFF))
		else $error("coil drive does not match step");
	a_pos_moves_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != $past(pos_q) |-> moving_q)
		else $error("position changed without a step");
	a_div_only_auto: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_rsp.done) |=> !manual_q && state_q == S_FIN)
		else $error("mapped target written in manual mode");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_free) |=> state_q == S_FIN && !in_ch.ready)
		else $error("result dropped while output full");
`endif

endmodule

// File: rtl/twsp_div.sv
module twsp_div import twsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIVR_W-1:0]    divisor_q;

	logic [DIVR_W:0] trial;
	logic [DIVR_W:0] diff;
	logic            fits;

	// one restoring step per cycle
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= '0;
			quo_q     <= req.dividend;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

`ifndef SYNTH
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a running division");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q && cnt_q == DIV_CNT_W'(DIVD_W - 1))
		else $error("divider did not start");
`endif

endmodule
